### rtl/ssg_pkg.sv
// ----------------------------------------------------------------------------
// Slope statistics grader package
// Shared request and response types, codes and constants of the grader.
// ----------------------------------------------------------------------------
package ssg_pkg;

   localparam int SLOPE_MAX  = 23040;
   localparam int LANES      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [1:0] OP_POINT    = 2'd0;
   localparam logic [1:0] OP_START    = 2'd1;
   localparam logic [1:0] OP_CANCEL   = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN_LIMIT = 2'd2;

   localparam logic KIND_CLOUD   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam int LANE_MEAN = 0;
   localparam int LANE_RMS  = 1;
   localparam int LANE_MAX  = 2;
   localparam int LANE_LOW  = 3;
   localparam int LANE_HIGH = 4;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [14:0]        slope;
      logic               slope_valid;
      logic signed [15:0] height;
      logic               coords_valid;
      logic               wall_flag;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic               report_kind;
      logic [4:0]         clouds_collected;
      logic [14:0]        mean_slope;
      logic [14:0]        rms_slope;
      logic [14:0]        max_slope;
      logic signed [15:0] min_height;
      logic signed [15:0] max_height;
      logic signed [15:0] mid_height;
      logic signed [15:0] slope_margin;
      logic               pass_flag;
      logic               last_result;
   } rsp_type;

   // One window entry: every series as an unsigned 16-bit lane, heights
   // stored with the sign bit flipped so that they order as unsigned values.
   typedef logic [LANES-1:0][15:0] lane_vec_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_RMS_START,
      ST_RMS_WAIT,
      ST_SQRT,
      ST_CLOUD_OUT,
      ST_PIVOT_REQ,
      ST_PIVOT,
      ST_SCAN,
      ST_ACC,
      ST_TRIM_START,
      ST_TRIM_WAIT,
      ST_SUM_OUT
   } back_state_type;

endpackage

### rtl/ssg_queue.sv
// ----------------------------------------------------------------------------
// Slope statistics grader queue
// Two-entry queue carrying cloud and summary records from front to back.
// ----------------------------------------------------------------------------
module ssg_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

### rtl/ssg_front.sv
// ----------------------------------------------------------------------------
// Slope statistics grader front
// Accepts point requests at full rate while the queue has room, keeps cloud
// sums and extrema, and queues a record per non-empty cloud or run command.
// ----------------------------------------------------------------------------
module ssg_front #(
   parameter int DEPTH      = 16,
   parameter int MAX_POINTS = 65536
) (
   clock, reset, req_push, req_data, req_full, need, q_full, q_push, q_data
);
   import ssg_pkg::*;

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SUM_W  = $clog2(longint'(MAX_POINTS) * SLOPE_MAX + 1);
   localparam int SQ_W   = $clog2(longint'(MAX_POINTS) * SLOPE_MAX * SLOPE_MAX + 1);
   localparam int REC_W  = 1 + SUM_W + SQ_W + 15 + CNT_W + 32;

   input  logic              clock;
   input  logic              reset;
   input  logic              req_push;
   input  ssg_pkg::req_type  req_data;
   output logic              req_full;
   input  logic [FILL_W-1:0] need;
   input  logic              q_full;
   output logic              q_push;
   output logic [REC_W-1:0]  q_data;

   logic               run_ff, run_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [14:0]        peak_ff, peak_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [15:0] low_ff, low_in;
   logic signed [15:0] high_ff, high_in;
   logic               seen_ff, seen_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               accept;

   assign req_full = q_full;
   assign accept   = req_push & ~q_full;

   always_comb begin
      logic [14:0] s;
      run_in  = run_ff;
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      peak_in = peak_ff;
      cnt_in  = cnt_ff;
      low_in  = low_ff;
      high_in = high_ff;
      seen_in = seen_ff;
      fill_in = fill_ff;
      q_push  = 1'b0;
      q_data  = '0;
      s = (32'(req_data.slope) > SLOPE_MAX) ? 15'(SLOPE_MAX) : req_data.slope;
      if (accept) begin
         case (req_data.opcode)
            OP_POINT: begin
               if (run_ff) begin
                  if (!req_data.wall_flag) begin
                     if (req_data.coords_valid) begin
                        if (req_data.height < low_ff) low_in = req_data.height;
                        if (req_data.height > high_ff) high_in = req_data.height;
                        seen_in = 1'b1;
                     end
                     if (req_data.slope_valid && cnt_ff < CNT_W'(MAX_POINTS)) begin
                        sum_in = sum_ff + SUM_W'(s);
                        sq_in  = sq_ff + SQ_W'(30'(s) * 30'(s));
                        if (s > peak_ff) peak_in = s;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  if (req_data.last_point) begin
                     if (seen_in && cnt_in != '0) begin
                        q_push  = 1'b1;
                        q_data  = {KIND_CLOUD, sum_in, sq_in, peak_in, cnt_in,
                                   low_in, high_in};
                        fill_in = fill_ff + 1'b1;
                        if (fill_in >= need) begin
                           run_in  = 1'b0;
                           fill_in = '0;
                        end
                     end
                     sum_in  = '0;
                     sq_in   = '0;
                     peak_in = '0;
                     cnt_in  = '0;
                     low_in  = 16'sh7FFF;
                     high_in = -16'sh8000;
                     seen_in = 1'b0;
                  end
               end
            end
            OP_START, OP_CANCEL: begin
               q_push  = 1'b1;
               q_data  = {KIND_SUMMARY, (REC_W - 1)'(0)};
               run_in  = (req_data.opcode == OP_START);
               fill_in = '0;
               sum_in  = '0;
               sq_in   = '0;
               peak_in = '0;
               cnt_in  = '0;
               low_in  = 16'sh7FFF;
               high_in = -16'sh8000;
               seen_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         sum_ff  <= '0;
         sq_ff   <= '0;
         peak_ff <= '0;
         cnt_ff  <= '0;
         low_ff  <= 16'sh7FFF;
         high_ff <= -16'sh8000;
         seen_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         run_ff  <= run_in;
         sum_ff  <= sum_in;
         sq_ff   <= sq_in;
         peak_ff <= peak_in;
         cnt_ff  <= cnt_in;
         low_ff  <= low_in;
         high_ff <= high_in;
         seen_ff <= seen_in;
         fill_ff <= fill_in;
      end
   end
endmodule

### rtl/ssg_divider.sv
// ----------------------------------------------------------------------------
// Slope statistics grader divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssg_divider #(
   parameter int DVD_W = 48,
   parameter int DVS_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);
   localparam int STEP_W = $clog2(DVD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      logic [DVS_W:0] shifted;
      logic [DVS_W:0] diff;
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end
endmodule

### rtl/ssg_back.sv
// ----------------------------------------------------------------------------
// Slope statistics grader back
// Turns cloud records into reports, keeps the window and computes the
// trimmed-mean summary by ranking each entry against the others.
// ----------------------------------------------------------------------------
module ssg_back #(
   parameter int DEPTH      = 16,
   parameter int MAX_POINTS = 65536
) (
   clock, reset, q_empty, q_data, q_pop, need, trim, margin_limit,
   rsp_empty, rsp_pop, rsp_data
);
   import ssg_pkg::*;

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SUM_W  = $clog2(longint'(MAX_POINTS) * SLOPE_MAX + 1);
   localparam int SQ_W   = $clog2(longint'(MAX_POINTS) * SLOPE_MAX * SLOPE_MAX + 1);
   localparam int REC_W  = 1 + SUM_W + SQ_W + 15 + CNT_W + 32;
   localparam int TSUM_W = 16 + FILL_W;
   localparam int DVD_W  = SQ_W + 2;
   localparam int DVS_W  = (CNT_W > FILL_W + 1) ? CNT_W : FILL_W + 1;

   input  logic              clock;
   input  logic              reset;
   input  logic              q_empty;
   input  logic [REC_W-1:0]  q_data;
   output logic              q_pop;
   input  logic [FILL_W-1:0] need;
   input  logic [2:0]        trim;
   input  logic [14:0]       margin_limit;
   output logic              rsp_empty;
   input  logic              rsp_pop;
   output ssg_pkg::rsp_type  rsp_data;

   back_state_type state_ff, state_in;

   logic [REC_W-1:0]   rec_ff;
   logic [SUM_W-1:0]   rec_sum;
   logic [SQ_W-1:0]    rec_sq;
   logic [14:0]        rec_peak;
   logic [CNT_W-1:0]   rec_cnt;
   logic signed [15:0] rec_low;
   logic signed [15:0] rec_high;

   logic [14:0]        mean_ff;
   logic [31:0]        rad_ff;
   logic [15:0]        root_ff;
   logic [3:0]         bit_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [IDX_W-1:0]   i_ff, j_ff;
   logic [2:0]         k_ff;
   lane_vec_type       pivot_ff, trim_ff, rd_data_ff;
   logic [FILL_W-1:0]  less_ff [LANES];
   logic [TSUM_W-1:0]  sums_ff [LANES];
   lane_vec_type       win_mem [DEPTH];
   logic               out_valid_ff;
   rsp_type            out_ff;

   logic               div_start, div_done;
   logic [DVD_W-1:0]   div_dividend, div_quotient;
   logic [DVS_W-1:0]   div_divisor;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_wr, out_load;
   rsp_type            out_next;
   lane_vec_type       entry;
   logic               trim_on;
   logic [FILL_W-1:0]  cnt_t;
   logic [FILL_W-1:0]  fill_next;
   logic               summary_due;
   logic [14:0]        rms_val;
   logic [FILL_W-1:0]  less_in [LANES];
   logic               lane_keep [LANES];
   logic               sqrt_last, scan_last, acc_last;

   assign {rec_sum, rec_sq, rec_peak, rec_cnt, rec_low, rec_high} = rec_ff[REC_W-2:0];

   ssg_divider #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_empty   = ~out_valid_ff;
   assign rsp_data    = out_ff;
   assign trim_on     = (32'(fill_ff) >= 2 * 32'(trim) + 1);
   assign cnt_t       = trim_on ? FILL_W'(32'(fill_ff) - 2 * 32'(trim)) : fill_ff;
   assign fill_next   = fill_ff + 1'b1;
   assign summary_due = (fill_next >= need);
   assign sqrt_last   = (bit_ff == 4'd0);
   assign scan_last   = (FILL_W'(j_ff) == fill_ff - 1'b1);
   assign acc_last    = (FILL_W'(i_ff) == fill_ff - 1'b1);

   always_comb begin
      logic [16:0] rounded;
      rounded = (17'(root_ff) + 17'd1) >> 1;
      rms_val = (32'(rounded) > SLOPE_MAX) ? 15'(SLOPE_MAX) : rounded[14:0];
   end

   always_comb begin
      entry[LANE_MEAN] = {1'b0, mean_ff};
      entry[LANE_RMS]  = {1'b0, rms_val};
      entry[LANE_MAX]  = {1'b0, rec_peak};
      entry[LANE_LOW]  = {~rec_low[15], rec_low[14:0]};
      entry[LANE_HIGH] = {~rec_high[15], rec_high[14:0]};
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         less_in[k] = less_ff[k];
         if (rd_data_ff[k] < pivot_ff[k] ||
             (rd_data_ff[k] == pivot_ff[k] && j_ff < i_ff)) begin
            less_in[k] = less_ff[k] + 1'b1;
         end
         lane_keep[k] = ~trim_on ||
                        (less_ff[k] >= FILL_W'(trim) &&
                         32'(less_ff[k]) < 32'(fill_ff) - 32'(trim));
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && q_data[REC_W-1] == KIND_CLOUD) state_in = ST_MEAN_START;
         end
         ST_MEAN_START: state_in = ST_MEAN_WAIT;
         ST_MEAN_WAIT:  if (div_done) state_in = ST_RMS_START;
         ST_RMS_START:  state_in = ST_RMS_WAIT;
         ST_RMS_WAIT:   if (div_done) state_in = ST_SQRT;
         ST_SQRT:       if (sqrt_last) state_in = ST_CLOUD_OUT;
         ST_CLOUD_OUT: begin
            if (!out_valid_ff) state_in = summary_due ? ST_PIVOT_REQ : ST_IDLE;
         end
         ST_PIVOT_REQ:  state_in = ST_PIVOT;
         ST_PIVOT:      state_in = ST_SCAN;
         ST_SCAN:       if (scan_last) state_in = ST_ACC;
         ST_ACC:        state_in = acc_last ? ST_TRIM_START : ST_PIVOT_REQ;
         ST_TRIM_START: state_in = ST_TRIM_WAIT;
         ST_TRIM_WAIT: begin
            if (div_done) state_in = (k_ff == 3'(LANES - 1)) ? ST_SUM_OUT : ST_TRIM_START;
         end
         ST_SUM_OUT:    if (!out_valid_ff) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      logic [16:0] mid17;
      logic [15:0] tl, th;
      logic [16:0] margin17;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      rd_addr      = i_ff;
      mem_wr       = 1'b0;
      out_load     = 1'b0;
      out_next     = '0;
      mid17        = '0;
      tl           = '0;
      th           = '0;
      margin17     = '0;
      case (state_ff)
         ST_IDLE: begin
            q_pop = ~q_empty;
         end
         ST_MEAN_START: begin
            div_start    = 1'b1;
            div_dividend = DVD_W'(rec_sum) + DVD_W'(rec_cnt >> 1);
            div_divisor  = DVS_W'(rec_cnt);
         end
         ST_RMS_START: begin
            div_start    = 1'b1;
            div_dividend = DVD_W'(rec_sq) << 2;
            div_divisor  = DVS_W'(rec_cnt);
         end
         ST_CLOUD_OUT: begin
            mid17 = (17'(rec_low) + 17'(rec_high)) >>> 1;
            out_next.report_kind      = KIND_CLOUD;
            out_next.clouds_collected = 5'(fill_next);
            out_next.mean_slope       = mean_ff;
            out_next.rms_slope        = rms_val;
            out_next.max_slope        = rec_peak;
            out_next.min_height       = rec_low;
            out_next.max_height       = rec_high;
            out_next.mid_height       = mid17[15:0];
            out_next.slope_margin     = '0;
            out_next.pass_flag        = 1'b0;
            out_next.last_result      = ~summary_due;
            out_load = ~out_valid_ff;
            mem_wr   = ~out_valid_ff && (32'(fill_ff) < DEPTH);
         end
         ST_PIVOT: begin
            rd_addr = '0;
         end
         ST_SCAN: begin
            rd_addr = j_ff + 1'b1;
         end
         ST_TRIM_START: begin
            div_start    = 1'b1;
            div_dividend = (DVD_W'(sums_ff[k_ff]) << 1) + DVD_W'(cnt_t);
            div_divisor  = DVS_W'(cnt_t) << 1;
         end
         ST_SUM_OUT: begin
            tl       = {~trim_ff[LANE_LOW][15], trim_ff[LANE_LOW][14:0]};
            th       = {~trim_ff[LANE_HIGH][15], trim_ff[LANE_HIGH][14:0]};
            mid17    = (17'($signed(tl)) + 17'($signed(th))) >>> 1;
            margin17 = {1'b0, trim_ff[LANE_MAX]} - {1'b0, trim_ff[LANE_MEAN]};
            out_next.report_kind      = KIND_SUMMARY;
            out_next.clouds_collected = 5'(fill_ff);
            out_next.mean_slope       = trim_ff[LANE_MEAN][14:0];
            out_next.rms_slope        = trim_ff[LANE_RMS][14:0];
            out_next.max_slope        = trim_ff[LANE_MAX][14:0];
            out_next.min_height       = tl;
            out_next.max_height       = th;
            out_next.mid_height       = mid17[15:0];
            out_next.slope_margin     = margin17[15:0];
            out_next.pass_flag        = ($signed(margin17) <= $signed({2'b00, margin_limit}));
            out_next.last_result      = 1'b1;
            out_load = ~out_valid_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         if (state_ff == ST_IDLE && !q_empty && q_data[REC_W-1] == KIND_SUMMARY) begin
            fill_ff <= '0;
         end else if (state_ff == ST_CLOUD_OUT && out_load) begin
            fill_ff <= fill_next;
         end else if (state_ff == ST_SUM_OUT && out_load) begin
            fill_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [15:0] t;
      t = root_ff | (16'd1 << bit_ff);
      if (out_load) out_ff <= out_next;
      if (mem_wr) win_mem[fill_ff[IDX_W-1:0]] <= entry;
      rd_data_ff <= win_mem[rd_addr];
      case (state_ff)
         ST_IDLE: begin
            rec_ff <= q_data;
         end
         ST_MEAN_WAIT: begin
            if (div_done) begin
               mean_ff <= (div_quotient > DVD_W'(SLOPE_MAX)) ? 15'(SLOPE_MAX)
                                                             : div_quotient[14:0];
            end
         end
         ST_RMS_WAIT: begin
            rad_ff  <= div_quotient[31:0];
            root_ff <= '0;
            bit_ff  <= 4'd15;
         end
         ST_SQRT: begin
            if (32'(t) * 32'(t) <= rad_ff) root_ff <= t;
            bit_ff <= bit_ff - 1'b1;
         end
         ST_CLOUD_OUT: begin
            i_ff <= '0;
            for (int k = 0; k < LANES; k++) sums_ff[k] <= '0;
         end
         ST_PIVOT: begin
            pivot_ff <= rd_data_ff;
            j_ff     <= '0;
            for (int k = 0; k < LANES; k++) less_ff[k] <= '0;
         end
         ST_SCAN: begin
            j_ff <= j_ff + 1'b1;
            for (int k = 0; k < LANES; k++) less_ff[k] <= less_in[k];
         end
         ST_ACC: begin
            for (int k = 0; k < LANES; k++) begin
               if (lane_keep[k]) sums_ff[k] <= sums_ff[k] + TSUM_W'(pivot_ff[k]);
            end
            i_ff <= i_ff + 1'b1;
            k_ff <= '0;
         end
         ST_TRIM_WAIT: begin
            if (div_done) begin
               trim_ff[k_ff] <= div_quotient[15:0];
               k_ff          <= k_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end
endmodule

### rtl/slope_stats_trimmed_window_grader.sv
// ----------------------------------------------------------------------------
// Slope statistics grader with trimmed-mean window
// Accumulates per-cloud slope and height statistics, reports each cloud and
// grades a window of clouds with trimmed means, margin and pass flag.
// ----------------------------------------------------------------------------
//   Channel   Ports                          Moves
//   req       req_push, req_full, req_data   one point or run command
//   rsp       rsp_empty, rsp_pop, rsp_data   one cloud report or summary
//   csr       csr_valid, csr_ready, ...      one register write
//
// The front takes one request per cycle and stalls only when its two-entry
// record queue is full. A cloud record occupies the back for two serial
// divisions and the square-root loop; a summary adds a ranking pass over the
// window entries and five more divisions.
// Synchronous reset clears all control state; the result register holds one
// report and the back waits while it is not taken.
// ----------------------------------------------------------------------------
module slope_stats_trimmed_window_grader #(
   parameter int WINDOW_DEPTH = 16,
   parameter int MAX_POINTS   = 65536
) (
   clock, reset,
   req_push, req_full, req_data,
   rsp_empty, rsp_pop, rsp_data,
   csr_valid, csr_ready, csr_index, csr_data
);
   import ssg_pkg::*;

   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SUM_W  = $clog2(longint'(MAX_POINTS) * SLOPE_MAX + 1);
   localparam int SQ_W   = $clog2(longint'(MAX_POINTS) * SLOPE_MAX * SLOPE_MAX + 1);
   localparam int REC_W  = 1 + SUM_W + SQ_W + 15 + CNT_W + 32;

   input  logic                               clock;
   input  logic                               reset;
   input  logic                               req_push;
   output logic                               req_full;
   input  ssg_pkg::req_type                   req_data;
   output logic                               rsp_empty;
   input  logic                               rsp_pop;
   output ssg_pkg::rsp_type                   rsp_data;
   input  logic                               csr_valid;
   output logic                               csr_ready;
   input  logic [ssg_pkg::CSR_IDX_W-1:0]      csr_index;
   input  logic [ssg_pkg::CSR_DATA_W-1:0]     csr_data;

   logic [4:0]        window_size_ff;
   logic [2:0]        trim_count_ff;
   logic [14:0]       margin_limit_ff;
   logic [FILL_W-1:0] need;
   logic              q_push, q_full, q_pop, q_empty;
   logic [REC_W-1:0]  q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff  <= 5'd10;
         trim_count_ff   <= 3'd1;
         margin_limit_ff <= 15'd1280;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_SIZE:  window_size_ff  <= csr_data[4:0];
            CSR_TRIM_COUNT:   trim_count_ff   <= csr_data[2:0];
            CSR_MARGIN_LIMIT: margin_limit_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (window_size_ff == 5'd0) begin
         need = FILL_W'(1);
      end else if (32'(window_size_ff) > WINDOW_DEPTH) begin
         need = FILL_W'(WINDOW_DEPTH);
      end else begin
         need = FILL_W'(window_size_ff);
      end
   end

   ssg_front #(.DEPTH(WINDOW_DEPTH), .MAX_POINTS(MAX_POINTS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .need     (need),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   ssg_queue #(.WIDTH(REC_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_rdata)
   );

   ssg_back #(.DEPTH(WINDOW_DEPTH), .MAX_POINTS(MAX_POINTS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_data       (q_rdata),
      .q_pop        (q_pop),
      .need         (need),
      .trim         (trim_count_ff),
      .margin_limit (margin_limit_ff),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );
endmodule
